@@ rtl/tpp_pkg.sv @@
// ----------------------------------------------------------------------------
// tpp_pkg: shared types and constants for the tftp packet parser
// Opcodes, field kinds, status codes, widths and the transfer structs.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // longest packet that is parsed; later bytes are flagged as overlength
    localparam int MAX_PACKET_BYTES = 1024;

    // byte position saturates at MAX_PACKET_BYTES + 1
    localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 2);
    localparam int OFF_W  = 11;
    localparam int DLEN_W = 10;

    localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(MAX_PACKET_BYTES);
    localparam logic [OFF_W-1:0]  OFF_MAX    = {OFF_W{1'b1}};
    localparam logic [DLEN_W-1:0] DLEN_MAX   = {DLEN_W{1'b1}};

    // opcodes
    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // field kinds
    localparam logic [2:0] FK_OPCODE   = 3'd0;
    localparam logic [2:0] FK_FILENAME = 3'd1;
    localparam logic [2:0] FK_MODE     = 3'd2;
    localparam logic [2:0] FK_BLOCK    = 3'd3;
    localparam logic [2:0] FK_DATA     = 3'd4;
    localparam logic [2:0] FK_ERRCODE  = 3'd5;
    localparam logic [2:0] FK_ERRTEXT  = 3'd6;
    localparam logic [2:0] FK_IGNORED  = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_OP    = 2'd2;
    localparam logic [1:0] ST_OVERLONG  = 2'd3;

    // string phase of request and error packets
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_DONE   = 2'd2
    } phase_t;

    // one input byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    // one tagged result
    typedef struct packed {
        logic [7:0]        out_byte;
        logic [2:0]        field_kind;
        logic [OFF_W-1:0]  field_offset;
        logic              packet_end;
        logic [1:0]        status;
        logic [15:0]       opcode;
        logic [15:0]       block_number;
        logic [15:0]       error_code;
        logic [DLEN_W-1:0] payload_len;
    } out_item_t;

endpackage

@@ rtl/tpp_in_stage.sv @@
// ----------------------------------------------------------------------------
// tpp_in_stage: input register
// Captures one byte per transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module tpp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tpp_pkg::in_item_t item,
    input  logic              pop,
    output logic              hold_valid,
    output tpp_pkg::in_item_t hold_item
);

    logic              valid_reg;
    logic              valid_next;
    tpp_pkg::in_item_t item_reg;
    logic              load;

    // space when empty or when the held byte leaves this cycle
    assign item_ready = !valid_reg || pop;
    assign load       = item_valid && item_ready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

@@ rtl/tpp_parse_core.sv @@
// ----------------------------------------------------------------------------
// tpp_parse_core: per-packet parse state and byte decode
// Tags the held byte with its field and offset, builds the end-of-packet
// summary and updates the packet state when the byte moves on.
// ----------------------------------------------------------------------------
module tpp_parse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  tpp_pkg::in_item_t  hold_item,
    input  logic               advance,
    output tpp_pkg::out_item_t result_next
);

    logic [tpp_pkg::POS_W-1:0] pos_reg;
    logic [tpp_pkg::POS_W-1:0] pos_next;
    logic [15:0]               opcode_reg;
    logic [15:0]               opcode_next;
    logic [15:0]               word_reg;
    logic [15:0]               word_next;
    tpp_pkg::phase_t           phase_reg;
    tpp_pkg::phase_t           phase_next;
    logic [tpp_pkg::OFF_W-1:0] offset_reg;
    logic [tpp_pkg::OFF_W-1:0] offset_next;

    logic [7:0]                b;
    logic [2:0]                kind;
    logic [tpp_pkg::OFF_W-1:0] off;
    logic [31:0]               data_off;
    logic [31:0]               pay_count;
    logic [1:0]                st;
    logic                      op_str;
    logic                      op_blk;
    logic                      op_known;

    assign b        = hold_item.in_byte;
    assign op_str   = (opcode_reg == tpp_pkg::OP_RRQ) || (opcode_reg == tpp_pkg::OP_WRQ)
                   || (opcode_reg == tpp_pkg::OP_ERROR);
    assign op_blk   = (opcode_reg == tpp_pkg::OP_DATA) || (opcode_reg == tpp_pkg::OP_ACK);
    assign data_off = 32'(pos_reg) - 32'd4;

    // field tagging and state update for this byte
    always_comb
    begin
        kind        = tpp_pkg::FK_IGNORED;
        off         = '0;
        opcode_next = opcode_reg;
        word_next   = word_reg;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        if (pos_reg < tpp_pkg::POS_MAX)
        begin
            if (pos_reg < tpp_pkg::POS_W'(2))
            begin
                kind        = tpp_pkg::FK_OPCODE;
                off         = tpp_pkg::OFF_W'(pos_reg[0]);
                opcode_next = {opcode_reg[7:0], b};
            end
            else if (op_str)
            begin
                if ((opcode_reg == tpp_pkg::OP_ERROR) && (pos_reg < tpp_pkg::POS_W'(4)))
                begin
                    kind      = tpp_pkg::FK_ERRCODE;
                    off       = tpp_pkg::OFF_W'(pos_reg[0]);
                    word_next = {word_reg[7:0], b};
                end
                else if ((phase_reg != tpp_pkg::PHASE_DONE)
                      && ((opcode_reg != tpp_pkg::OP_ERROR)
                          || (phase_reg == tpp_pkg::PHASE_FIRST)))
                begin
                    if (b == 8'd0)
                    begin
                        // zero terminator closes the current string
                        if ((opcode_reg == tpp_pkg::OP_ERROR)
                            || (phase_reg == tpp_pkg::PHASE_SECOND))
                        begin
                            phase_next = tpp_pkg::PHASE_DONE;
                        end
                        else
                        begin
                            phase_next = tpp_pkg::PHASE_SECOND;
                        end
                        offset_next = '0;
                    end
                    else
                    begin
                        if (opcode_reg == tpp_pkg::OP_ERROR)
                        begin
                            kind = tpp_pkg::FK_ERRTEXT;
                        end
                        else if (phase_reg == tpp_pkg::PHASE_SECOND)
                        begin
                            kind = tpp_pkg::FK_MODE;
                        end
                        else
                        begin
                            kind = tpp_pkg::FK_FILENAME;
                        end
                        off = offset_reg;
                        if (offset_reg != tpp_pkg::OFF_MAX)
                        begin
                            offset_next = offset_reg + 1'b1;
                        end
                    end
                end
            end
            else if (op_blk)
            begin
                if (pos_reg < tpp_pkg::POS_W'(4))
                begin
                    kind      = tpp_pkg::FK_BLOCK;
                    off       = tpp_pkg::OFF_W'(pos_reg[0]);
                    word_next = {word_reg[7:0], b};
                end
                else if (opcode_reg == tpp_pkg::OP_DATA)
                begin
                    kind = tpp_pkg::FK_DATA;
                    if (data_off > 32'(tpp_pkg::OFF_MAX))
                    begin
                        off = tpp_pkg::OFF_MAX;
                    end
                    else
                    begin
                        off = data_off[tpp_pkg::OFF_W-1:0];
                    end
                end
            end
        end
    end

    // saturating byte count, this byte included
    assign pos_next  = (pos_reg <= tpp_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign pay_count = 32'(pos_next) - 32'd4;
    assign op_known  = (opcode_next >= tpp_pkg::OP_RRQ) && (opcode_next <= tpp_pkg::OP_ERROR);

    // packet status, overlength first
    always_comb
    begin
        if (pos_next > tpp_pkg::POS_MAX)
        begin
            st = tpp_pkg::ST_OVERLONG;
        end
        else if (pos_next < tpp_pkg::POS_W'(2))
        begin
            st = tpp_pkg::ST_SHORT;
        end
        else if (!op_known)
        begin
            st = tpp_pkg::ST_BAD_OP;
        end
        else if ((opcode_next >= tpp_pkg::OP_DATA) && (pos_next < tpp_pkg::POS_W'(4)))
        begin
            st = tpp_pkg::ST_SHORT;
        end
        else
        begin
            st = tpp_pkg::ST_OK;
        end
    end

    // result assembly, summary only on the last byte
    always_comb
    begin
        result_next              = '0;
        result_next.out_byte     = b;
        result_next.field_kind   = kind;
        result_next.field_offset = off;
        result_next.packet_end   = hold_item.is_last;
        if (hold_item.is_last)
        begin
            result_next.status = st;
            if (pos_next >= tpp_pkg::POS_W'(2))
            begin
                result_next.opcode = opcode_next;
            end
            if ((st == tpp_pkg::ST_OK)
                && ((opcode_next == tpp_pkg::OP_DATA) || (opcode_next == tpp_pkg::OP_ACK)))
            begin
                result_next.block_number = word_next;
            end
            if ((st == tpp_pkg::ST_OK) && (opcode_next == tpp_pkg::OP_ERROR))
            begin
                result_next.error_code = word_next;
            end
            if ((st == tpp_pkg::ST_OK) && (opcode_next == tpp_pkg::OP_DATA))
            begin
                if (pay_count > 32'(tpp_pkg::DLEN_MAX))
                begin
                    result_next.payload_len = tpp_pkg::DLEN_MAX;
                end
                else
                begin
                    result_next.payload_len = pay_count[tpp_pkg::DLEN_W-1:0];
                end
            end
        end
    end

    // packet state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            opcode_reg <= '0;
            word_reg   <= '0;
            phase_reg  <= tpp_pkg::PHASE_FIRST;
            offset_reg <= '0;
        end
        else if (advance)
        begin
            if (hold_item.is_last)
            begin
                pos_reg    <= '0;
                opcode_reg <= '0;
                word_reg   <= '0;
                phase_reg  <= tpp_pkg::PHASE_FIRST;
                offset_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                opcode_reg <= opcode_next;
                word_reg   <= word_next;
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
            end
        end
    end

    // checks
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= tpp_pkg::POS_MAX + 1'b1)
        else $error("byte position beyond saturation");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && hold_item.is_last |=> pos_reg == '0 && phase_reg == tpp_pkg::PHASE_FIRST
                                         && offset_reg == '0)
        else $error("state not cleared after last byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pos_reg) && $stable(opcode_reg) && $stable(phase_reg))
        else $error("packet state moved without a byte");

endmodule

@@ rtl/tftp_packet_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tftp_packet_parser_unit: tftp packet parser, one byte per transfer
// Path: each byte is held in the input register, then decoded into the
// result register. Throughput: one byte per cycle unless result_ready stalls,
// set by the single-pass decode against the per-packet state registers
// between input and result registers.
// Reset: rst_n clears both valid flags and the packet state.
// ----------------------------------------------------------------------------
module tftp_packet_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tpp_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output tpp_pkg::out_item_t result
);

    logic               hold_valid;
    tpp_pkg::in_item_t  hold_item;
    logic               advance;
    tpp_pkg::out_item_t result_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    tpp_pkg::out_item_t res_reg;

    // held byte moves on when the result register is free or draining
    assign advance = hold_valid && (!res_valid_reg || result_ready);

    tpp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pop        (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    tpp_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold_item   (hold_item),
        .advance     (advance),
        .result_next (result_next)
    );

    // result register occupancy
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // checks
    a_full_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && hold_valid |-> advance)
        else $error("input transfer into an occupied stage");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.packet_end |-> result.status == tpp_pkg::ST_OK
            && result.opcode == '0 && result.block_number == '0
            && result.error_code == '0 && result.payload_len == '0)
        else $error("summary fields set before packet end");

    a_ignored_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.field_kind == tpp_pkg::FK_IGNORED |-> result.field_offset == '0)
        else $error("ignored byte with non-zero offset");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("decoded byte lost");

endmodule
